/* hdl/pss_pkg.sv */
// pss_pkg: shared constants, types and helpers of the plucked string synth
// no dependencies; imported by every module of the block but pss_ram

package pss_pkg;

	// ring geometry
	localparam int MAX_DELAY = 4096;
	localparam int ADDR_W    = $clog2(MAX_DELAY);
	localparam int LEN_W     = ADDR_W + 1;

	// fixed field widths
	localparam int SAMPLE_W   = 16;
	localparam int VEL_W      = 16;
	localparam int DL_W       = 13;
	localparam int DECAY_W    = 17;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 17;
	localparam int PROD_W     = 2 * DECAY_W;

	// register reset values and saturation limits
	localparam logic [DL_W-1:0]    DL_RESET    = 13'd100;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 17'd65274;
	localparam logic [DECAY_W-1:0] DECAY_ONE   = 17'd65536;
	localparam logic [VEL_W-1:0]   VEL_ONE     = 16'd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELAY_LENGTH = 1'b0,
		REG_DECAY        = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		OP_TICK  = 1'b0,
		OP_PLUCK = 1'b1
	} opcode_t;

	// effective ring settings derived from the config registers
	typedef struct packed {
		logic [LEN_W-1:0]   len;
		logic [ADDR_W-1:0]  last;
		logic [ADDR_W-1:0]  half;
		logic [DECAY_W-1:0] decay;
	} ring_cfg_t;

	// negative pluck level: minus the saturated velocity
	function automatic logic [SAMPLE_W-1:0] pluck_lo(input logic [VEL_W-1:0] vel);
		logic [VEL_W-1:0] v;
		v = (vel > VEL_ONE) ? VEL_ONE : vel;
		return SAMPLE_W'(-v);
	endfunction

	// positive pluck level: (32767 * v) >> 15, which is v - 1 for any nonzero v
	function automatic logic [SAMPLE_W-1:0] pluck_hi(input logic [VEL_W-1:0] vel);
		logic [VEL_W-1:0] v;
		v = (vel > VEL_ONE) ? VEL_ONE : vel;
		return (v == '0) ? '0 : SAMPLE_W'(v - 1'b1);
	endfunction

endpackage

/* hdl/pss_ram.sv */
// pss_ram: generic single write port, single read port ram with registered read
// no dependencies

module pss_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/pss_cfg.sv */
// pss_cfg: configuration registers and the clamped ring settings
// depends on pss_pkg

module pss_cfg
	import pss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output ring_cfg_t             rcfg
);

	logic [DL_W-1:0]    dl_q;
	logic [DECAY_W-1:0] decay_q;
	logic [LEN_W-1:0]   len;
	logic [LEN_W-1:0]   len_m1;

	assign cfg_ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dl_q    <= DL_RESET;
			decay_q <= DECAY_RESET;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_DELAY_LENGTH: dl_q    <= cfg_data[DL_W-1:0];
				REG_DECAY:        decay_q <= cfg_data[DECAY_W-1:0];
				default:          ;
			endcase
		end
	end

	// clamp length to 2..MAX_DELAY, saturate decay at one
	always_comb begin
		if (32'(dl_q) < 32'd2) begin
			len = LEN_W'(2);
		end else if (32'(dl_q) > 32'(MAX_DELAY)) begin
			len = LEN_W'(MAX_DELAY);
		end else begin
			len = LEN_W'(dl_q);
		end
		len_m1     = len - 1'b1;
		rcfg.len   = len;
		rcfg.last  = len_m1[ADDR_W-1:0];
		rcfg.half  = len[LEN_W-1:1];
		rcfg.decay = (decay_q > DECAY_ONE) ? DECAY_ONE : decay_q;
	end

endmodule

/* hdl/pss_mix.sv */
// pss_mix: two stage decayed average, (a + b) * decay >> 17 toward zero
// depends on pss_pkg

module pss_mix
	import pss_pkg::*;
(
	input  logic                clk,
	input  logic [SAMPLE_W-1:0] a,
	input  logic [SAMPLE_W-1:0] b,
	input  logic [DECAY_W-1:0]  decay,
	output logic [SAMPLE_W-1:0] result
);

	logic [SAMPLE_W:0]   sum;
	logic [SAMPLE_W:0]   mag;
	logic [SAMPLE_W:0]   mag_s1;
	logic                neg_s1;
	logic [PROD_W-1:0]   prod_s2;
	logic                neg_s2;
	logic [DECAY_W-1:0]  scaled;
	logic [DECAY_W-1:0]  scaled_neg;

	// sign extended sum and its magnitude
	always_comb begin
		sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
		mag = sum[SAMPLE_W] ? (SAMPLE_W+1)'(-sum) : sum;
	end

	// stage 1: magnitude, stage 2: product
	always_ff @(posedge clk) begin
		mag_s1  <= mag;
		neg_s1  <= sum[SAMPLE_W];
		prod_s2 <= PROD_W'(mag_s1) * PROD_W'(decay);
		neg_s2  <= neg_s1;
	end

	// scale down and restore the sign
	always_comb begin
		scaled     = prod_s2[PROD_W-1:PROD_W-DECAY_W];
		scaled_neg = -scaled;
		result     = neg_s2 ? scaled_neg[SAMPLE_W-1:0] : scaled[SAMPLE_W-1:0];
	end

endmodule

/* hdl/plucked_string_synth.sv */
// plucked_string_synth: top level, sequencer around the ring memory
// depends on pss_pkg, pss_cfg, pss_mix, pss_ram
// tick after a pluck: S_RD_NX, S_MIX_IN, S_MIX_MUL and S_WB, then S_EMIT registers the result
// tick before any pluck: S_EMIT registers a zero result; in_ready is high only in S_IDLE
// pluck: S_FILL writes every ring entry, one ring entry written per cycle
// tick cost is set by the single ram read port (two reads) and the two stage mix pipeline
// arst_n clears the head, the pluck flag, config registers and handshakes; ring is not cleared

module plucked_string_synth
	import pss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [VEL_W-1:0]      velocity,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [SAMPLE_W-1:0]   sample,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_RD_NX,
		S_MIX_IN,
		S_MIX_MUL,
		S_WB,
		S_EMIT
	} state_t;

	state_t              state_q;
	ring_cfg_t           rcfg;
	logic [ADDR_W-1:0]   head_q;
	logic                plucked_q;
	logic [ADDR_W-1:0]   h_q;
	logic [ADDR_W-1:0]   nx_q;
	logic [ADDR_W-1:0]   fill_q;
	logic [SAMPLE_W-1:0] res_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;
	logic                out_valid_q;
	logic [SAMPLE_W-1:0] sample_q;

	logic                in_beat;
	logic [ADDR_W-1:0]   h_calc;
	logic [LEN_W-1:0]    h_inc;
	logic [ADDR_W-1:0]   nx_calc;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [SAMPLE_W-1:0] ram_wdata;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [SAMPLE_W-1:0] mix_res;

	pss_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rcfg      (rcfg)
	);

	pss_mix u_mix (
		.clk    (clk),
		.a      (res_q),
		.b      (ram_rdata),
		.decay  (rcfg.decay),
		.result (mix_res)
	);

	pss_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (MAX_DELAY)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	// head wraps if the ring shrank, next entry wraps at the end
	always_comb begin
		h_calc  = ({1'b0, head_q} >= rcfg.len) ? '0 : head_q;
		h_inc   = {1'b0, h_calc} + 1'b1;
		nx_calc = (h_inc >= rcfg.len) ? '0 : h_inc[ADDR_W-1:0];
	end

	// ring access: head read on accept, next read after, fill or write back
	always_comb begin
		ram_raddr = (state_q == S_IDLE) ? h_calc : nx_q;
		ram_we    = (state_q == S_FILL) || (state_q == S_WB);
		if (state_q == S_FILL) begin
			ram_waddr = fill_q;
			ram_wdata = (fill_q < rcfg.half) ? lo_q : hi_q;
		end else begin
			ram_waddr = h_q;
			ram_wdata = mix_res;
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			plucked_q   <= 1'b0;
			h_q         <= '0;
			nx_q        <= '0;
			fill_q      <= '0;
			res_q       <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
		end else begin
			// output register: load a new result or retire a taken beat
			if (state_q == S_EMIT && (!out_valid_q || out_ready)) begin
				sample_q    <= res_q;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						if (opcode_t'(opcode) == OP_PLUCK) begin
							lo_q    <= pluck_lo(velocity);
							hi_q    <= pluck_hi(velocity);
							fill_q  <= '0;
							state_q <= S_FILL;
						end else if (!plucked_q) begin
							res_q   <= '0;
							state_q <= S_EMIT;
						end else begin
							h_q     <= h_calc;
							nx_q    <= nx_calc;
							state_q <= S_RD_NX;
						end
					end
				end
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == rcfg.last) begin
						head_q    <= '0;
						plucked_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_RD_NX: begin
					// head sample arrives
					res_q   <= ram_rdata;
					state_q <= S_MIX_IN;
				end
				S_MIX_IN: begin
					state_q <= S_MIX_MUL;
				end
				S_MIX_MUL: begin
					state_q <= S_WB;
				end
				S_WB: begin
					head_q  <= nx_q;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* hdl/pss_checker.sv */
// pss_checker: port level checks of the plucked string synth, bound to the top level
// depends on pss_pkg and plucked_string_synth

module pss_checker
	import pss_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                opcode,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] sample
);

	logic seen_pluck_q;

	// remembers whether any pluck beat went in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_pluck_q <= 1'b0;
		end else if (in_valid && in_ready && opcode_t'(opcode) == OP_PLUCK) begin
			seen_pluck_q <= 1'b1;
		end
	end

	// a stalled result beat holds its sample
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample))
		else $error("result beat changed while stalled");

	// valid drops only after a beat
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result beat dropped without being taken");

	// every item keeps the block busy in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on back to back cycles");

	// silence until the string is plucked
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_pluck_q |-> sample == '0)
		else $error("nonzero sample before any pluck");

endmodule

bind plucked_string_synth pss_checker u_pss_checker (.*);

/* tb/plucked_string_check.sv */
`timescale 1ns / 100ps
// plucked_string_check: watches the item, sample and register channels of the synth,
// keeps its own copy of the string ring and compares every sample beat with the prediction
// depends on pss_pkg

module plucked_string_check
	import pss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic                  opcode,
	input  logic [VEL_W-1:0]      velocity,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [SAMPLE_W-1:0]   sample,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    samples_owed
);

	// predicted string state and register copies
	logic signed [SAMPLE_W-1:0] ring_model [MAX_DELAY];
	logic [DL_W-1:0]            len_reg;
	logic [DECAY_W-1:0]         decay_reg;
	int                         head_pos;
	logic                       struck;
	logic signed [SAMPLE_W-1:0] samples_due [$];

	// ring length after clamping the register
	function automatic int ring_len();
		if (len_reg < 2) return 2;
		if (len_reg > MAX_DELAY) return MAX_DELAY;
		return int'(len_reg);
	endfunction

	// (a + b) * decay >> 17, magnitude truncated toward zero
	function automatic logic signed [SAMPLE_W-1:0] damped_average(
		input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W-1:0] b,
		input logic [DECAY_W-1:0]         d
	);
		longint gain, total, mag, scaled;
		gain   = (d > DECAY_ONE) ? longint'(DECAY_ONE) : longint'(d);
		total  = longint'(a) + longint'(b);
		mag    = (total < 0) ? -total : total;
		scaled = (mag * gain) >>> 17;
		return (total < 0) ? SAMPLE_W'(-scaled) : SAMPLE_W'(scaled);
	endfunction

	// apply one item to the predicted string, queue the sample a tick owes
	task automatic play_item(input opcode_t op, input logic [VEL_W-1:0] vel);
		int n, v, lo, hi, h, nx;
		logic signed [SAMPLE_W-1:0] cur;
		n = ring_len();
		if (op == OP_PLUCK) begin
			v  = (vel > VEL_ONE) ? int'(VEL_ONE) : int'(vel);
			lo = -v;
			hi = (32767 * v) >>> 15;
			for (int i = 0; i < n; i++)
				ring_model[i] = (i < n / 2) ? SAMPLE_W'(lo) : SAMPLE_W'(hi);
			head_pos = 0;
			struck   = 1'b1;
		end else if (!struck) begin
			samples_due.push_back('0);
		end else begin
			h = head_pos;
			if (h >= n) h = 0;
			nx = h + 1;
			if (nx >= n) nx = 0;
			cur = ring_model[h];
			samples_due.push_back(cur);
			ring_model[h] = damped_average(cur, ring_model[nx], decay_reg);
			head_pos = nx;
		end
	endtask

	task automatic flag_sample(input string why);
		if (mismatches < 10) $display("sample mismatch: %s", why);
		mismatches <= mismatches + 1;
	endtask

	initial begin
		for (int i = 0; i < MAX_DELAY; i++) ring_model[i] = '0;
	end

	// per-edge bookkeeping of all three channels
	always @(posedge clk or negedge arst_n) begin : watch
		logic signed [SAMPLE_W-1:0] want;
		if (!arst_n) begin
			len_reg   = DL_RESET;
			decay_reg = DECAY_RESET;
			head_pos  = 0;
			struck    = 1'b0;
			samples_due.delete();
			mismatches   <= 0;
			samples_owed <= 0;
		end else begin
			// a sample beat can only belong to an earlier item
			if (out_valid && out_ready) begin
				if (samples_due.size() == 0) begin
					flag_sample($sformatf("beat with no tick waiting, got %0d",
						$signed(sample)));
				end else begin
					want = samples_due.pop_front();
					if (sample !== want)
						flag_sample($sformatf("expected %0d got %0d", want, $signed(sample)));
				end
			end
			// register write beat
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_DELAY_LENGTH: len_reg = cfg_data[DL_W-1:0];
					REG_DECAY:        decay_reg = cfg_data[DECAY_W-1:0];
					default:          ;
				endcase
			end
			// item beat
			if (in_valid && in_ready) play_item(opcode_t'(opcode), velocity);
			samples_owed <= samples_due.size();
		end
	end

endmodule

/* tb/plucked_string_synth_test.sv */
`timescale 1ns / 100ps
// plucked_string_synth_test: drives plucks, ticks and register writes into the synth
// depends on pss_pkg, plucked_string_synth and plucked_string_check

module plucked_string_synth_test;
	import pss_pkg::*;

	localparam int QUIET_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 725;
	localparam int HOLD_CYCLES  = 400;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic                  opcode;
	logic [VEL_W-1:0]      velocity;
	logic                  out_valid;
	logic                  out_ready;
	logic [SAMPLE_W-1:0]   sample;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    samples_owed;
	int                    quiet_cycles = 0;

	// stimulus bookkeeping: current ring length and how much of the ring a pluck has written
	bit calm;
	bit hold_off;
	bit plucked_once;
	bit must_pluck;
	int len_now;
	int filled_len;

	plucked_string_synth uut (.*);

	plucked_string_check watch (.*);

	always #5 clk = ~clk;

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// sample receiver: random stalls, a calm stretch and one long hold-off
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 22);
			end
		end
	end

	// offer one item and hold it until its beat
	task automatic send_item(input opcode_t op, input logic [VEL_W-1:0] vel);
		if (!calm && $urandom_range(99) < 22) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 22);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		velocity <= vel;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == OP_PLUCK) begin
			plucked_once = 1'b1;
			if (len_now > filled_len) filled_len = len_now;
		end
	endtask

	// stop offering, wait for every owed sample, then let a pluck finish its fill
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (samples_owed != 0) @(posedge clk);
		repeat (len_now + 20) @(posedge clk);
	endtask

	// write both registers while the block is idle
	task automatic tune(input logic [DL_W-1:0] dl, input logic [DECAY_W-1:0] dc);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_DELAY_LENGTH;
		cfg_data  <= CFG_DATA_W'(dl);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_DECAY;
		cfg_data  <= CFG_DATA_W'(dc);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		len_now = (dl < 2) ? 2 : (dl > MAX_DELAY) ? MAX_DELAY : int'(dl);
		// a longer ring than any pluck has filled must be plucked before it is read
		must_pluck = plucked_once && (len_now > filled_len);
	endtask

	task automatic pluck_random();
		if ($urandom_range(99) < 15) send_item(OP_PLUCK, VEL_W'($urandom_range(65535, 32769)));
		else send_item(OP_PLUCK, VEL_W'($urandom_range(32768, 0)));
	endtask

	initial begin
		int sent, phase, n;
		logic [DL_W-1:0]    dl;
		logic [DECAY_W-1:0] dc;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		opcode    <= OP_TICK;
		velocity  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_DELAY_LENGTH;
		cfg_data  <= '0;
		calm         = 1'b0;
		hold_off     = 1'b0;
		plucked_once = 1'b0;
		must_pluck   = 1'b0;
		len_now      = DL_RESET;
		filled_len   = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// ticks before any pluck give silence
		send_item(OP_TICK, 16'hFFFF);
		send_item(OP_TICK, 16'h0000);
		// velocity extremes at the reset length and decay, one above full scale
		send_item(OP_PLUCK, 16'hFFFF);
		send_item(OP_TICK, 16'h5555);
		send_item(OP_TICK, 16'hAAAA);
		send_item(OP_PLUCK, 16'd0);
		send_item(OP_TICK, 16'd0);
		send_item(OP_PLUCK, 16'd1);
		send_item(OP_TICK, 16'd0);
		send_item(OP_PLUCK, VEL_ONE);
		repeat (6) send_item(OP_TICK, 16'd0);
		// shrink the ring under the head so it wraps to entry zero, decay of exactly one
		tune(13'd4, DECAY_ONE);
		repeat (3) send_item(OP_TICK, 16'd0);
		// length below the minimum, decay above one
		tune(13'd0, 17'h1FFFF);
		send_item(OP_PLUCK, 16'd32767);
		repeat (2) send_item(OP_TICK, 16'd0);
		// length above the maximum, zero decay
		tune(13'h1FFF, 17'd0);
		send_item(OP_PLUCK, VEL_ONE);
		repeat (2) send_item(OP_TICK, 16'd0);

		// random phases: mostly short rings, mostly ticks
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case ($urandom_range(19))
				0:       dl = DL_W'($urandom_range(1, 0));
				1:       dl = DL_W'($urandom_range(8191, 4096));
				2:       dl = DL_W'($urandom_range(600, 100));
				default: dl = DL_W'($urandom_range(48, 2));
			endcase
			case ($urandom_range(9))
				0:       dc = '0;
				1:       dc = DECAY_ONE;
				2:       dc = DECAY_W'($urandom_range(131071, 65537));
				3:       dc = DECAY_W'($urandom_range(65535, 0));
				default: dc = DECAY_W'($urandom_range(65536, 60000));
			endcase
			tune(dl, dc);
			calm = (phase == 3);
			if (phase == 1) hold_off = 1'b1;
			n = calm ? 120 : $urandom_range(60, 20);
			for (int i = 0; i < n; i++) begin
				if ((i == 0 && must_pluck) || $urandom_range(99) < 8) pluck_random();
				else send_item(OP_TICK, VEL_W'($urandom_range(65535, 0)));
			end
			sent += n;
			phase++;
		end
		calm = 1'b0;

		settle();
		if (mismatches == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule
